[rtl/core/cprq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Class priority request queue package
// Shared widths, codes and types for the queue core and its cells.
// ----------------------------------------------------------------------------
package cprq_pkg;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;

  localparam int unsigned CLASS_W   = 4;
  localparam int unsigned PRI_W     = 2;
  localparam int unsigned LIMIT_W   = 5;
  localparam int unsigned FILL_W    = 5;
  localparam int unsigned PRI_LEVELS = 4;

  localparam logic [PRI_W-1:0]   TOP_PRIORITY = 2'd3;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 5'd16;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_TAKE = 1'b1;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic match_en;  // register the compare against the asked-for class
    logic take_en;   // remove the selected entry and close the gap
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_MATCH  = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

endpackage
`default_nettype wire

[rtl/core/cprq_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Queue cell
// Holds one queue entry, compares it against the asked-for class and shifts
// in its neighbor's entry when an entry at or ahead of it is removed.
// ----------------------------------------------------------------------------
module cprq_cell (
  input  logic                                clk_i,
  input  cprq_pkg::cell_ctrl_t                ctrl_i,
  input  logic                                valid_i,
  input  logic                                load_new_i,
  input  logic [cprq_pkg::CLASS_W-1:0]        cls_i,
  input  logic [cprq_pkg::PRI_W-1:0]          pri_i,
  input  logic [cprq_pkg::PRI_W-1:0]          best_pri_i,
  input  logic                                seen_i,
  input  logic [cprq_pkg::CLASS_W-1:0]        next_cls_i,
  input  logic [cprq_pkg::PRI_W-1:0]          next_pri_i,
  output logic                                seen_o,
  output logic [cprq_pkg::CLASS_W-1:0]        cls_o,
  output logic [cprq_pkg::PRI_W-1:0]          pri_o,
  output logic [cprq_pkg::PRI_LEVELS-1:0]     hit_lvl_o
);

  logic [cprq_pkg::CLASS_W-1:0] cls_q;
  logic [cprq_pkg::PRI_W-1:0]   pri_q;
  logic                         hit_q;
  logic                         sel_here;

  // The first cell holding a best-priority hit is removed; every cell from
  // there on takes its neighbor's entry.
  assign sel_here = ctrl_i.take_en && hit_q && (pri_q == best_pri_i);
  assign seen_o   = seen_i || sel_here;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.match_en) begin
      hit_q <= valid_i && (cls_q == cls_i);
    end
    if (load_new_i) begin
      cls_q <= cls_i;
      pri_q <= pri_i;
    end else if (ctrl_i.take_en && seen_o) begin
      cls_q <= next_cls_i;
      pri_q <= next_pri_i;
    end
  end

  always_comb begin
    for (int k = 0; k < cprq_pkg::PRI_LEVELS; k++) begin
      hit_lvl_o[k] = hit_q && (pri_q == cprq_pkg::PRI_W'(k));
    end
  end

  assign cls_o = cls_q;
  assign pri_o = pri_q;

endmodule
`default_nettype wire

[rtl/core/class_priority_request_queue.sv]
`default_nettype none
// An input transfer moves to the match state, where every cell registers its
// class compare, then to the commit state, where the select and shift are done
// and the result is registered. A new item is taken only in the idle state, so
// not before the last one commits; a result still waiting on the output holds the commit state.
// Reset clears the queue to empty, the limit to 16 and the output to idle.
// ----------------------------------------------------------------------------
// Class priority request queue
// Arrival-ordered queue of (class, priority) requests held in a row of
// cells; a take removes the earliest best-priority entry of a class.
// ----------------------------------------------------------------------------
module class_priority_request_queue #(
  parameter int unsigned QUEUE_DEPTH = cprq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,     // queue_limit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [3:0] req_class, [5:4] req_priority
  input  logic        s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [3:0] out_class, [5:4] out_priority,
                                      // [10:6] fill_level
  output logic        m_axis_tuser    // [0] done_res
);

  localparam int unsigned CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > cprq_pkg::LIMIT_W) ? CW : cprq_pkg::LIMIT_W;

  cprq_pkg::state_e state_q, state_d;

  logic [cprq_pkg::LIMIT_W-1:0] limit_q;
  logic [CW-1:0]                count_q, count_d;
  logic                         act_q;
  logic [cprq_pkg::CLASS_W-1:0] cls_q;
  logic [cprq_pkg::PRI_W-1:0]   pri_q;

  logic                         out_valid_q;
  logic                         out_done_q, out_done_d;
  logic [cprq_pkg::CLASS_W-1:0] out_cls_q, out_cls_d;
  logic [cprq_pkg::PRI_W-1:0]   out_pri_q, out_pri_d;
  logic [cprq_pkg::FILL_W-1:0]  out_fill_q, out_fill_d;

  logic                         in_fire;
  logic                         slot_free;
  logic                         commit_fire;
  logic                         push_ok;
  logic                         found;
  logic [cprq_pkg::PRI_W-1:0]   best_pri;
  logic [cprq_pkg::PRI_LEVELS-1:0] any_lvl;
  logic [CMPW-1:0]              count_ext;

  cprq_pkg::cell_ctrl_t         cell_ctrl;

  logic [QUEUE_DEPTH:0]         seen;
  logic [QUEUE_DEPTH-1:0]       cell_valid;
  logic [QUEUE_DEPTH-1:0]       load_new;
  logic [cprq_pkg::CLASS_W-1:0] cell_cls [QUEUE_DEPTH];
  logic [cprq_pkg::PRI_W-1:0]   cell_pri [QUEUE_DEPTH];
  logic [cprq_pkg::PRI_LEVELS-1:0] hit_lvl [QUEUE_DEPTH];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == cprq_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign commit_fire   = (state_q == cprq_pkg::ST_COMMIT) && slot_free;

  assign push_ok = (CMPW'(count_q) < CMPW'(limit_q)) && (count_q < CW'(QUEUE_DEPTH));

  // Best priority over all registered hits.
  always_comb begin
    any_lvl = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      any_lvl = any_lvl | hit_lvl[i];
    end
  end

  always_comb begin
    found = |any_lvl;
    if (any_lvl[3]) begin
      best_pri = cprq_pkg::TOP_PRIORITY;
    end else if (any_lvl[2]) begin
      best_pri = 2'd2;
    end else if (any_lvl[1]) begin
      best_pri = 2'd1;
    end else begin
      best_pri = 2'd0;
    end
  end

  assign cell_ctrl.match_en = (state_q == cprq_pkg::ST_MATCH);
  assign cell_ctrl.take_en  = commit_fire && (act_q == cprq_pkg::ACT_TAKE) && found;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_valid[i] = CW'(i) < count_q;
      load_new[i]   = commit_fire && (act_q == cprq_pkg::ACT_PUSH) && push_ok
                      && (count_q == CW'(i));
    end
  end

  assign seen[0] = 1'b0;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [cprq_pkg::CLASS_W-1:0] nxt_cls;
    logic [cprq_pkg::PRI_W-1:0]   nxt_pri;

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign nxt_cls = '0;
      assign nxt_pri = '0;
    end else begin : g_mid
      assign nxt_cls = cell_cls[g+1];
      assign nxt_pri = cell_pri[g+1];
    end

    cprq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .valid_i    (cell_valid[g]),
      .load_new_i (load_new[g]),
      .cls_i      (cls_q),
      .pri_i      (pri_q),
      .best_pri_i (best_pri),
      .seen_i     (seen[g]),
      .next_cls_i (nxt_cls),
      .next_pri_i (nxt_pri),
      .seen_o     (seen[g+1]),
      .cls_o      (cell_cls[g]),
      .pri_o      (cell_pri[g]),
      .hit_lvl_o  (hit_lvl[g])
    );
  end

  // Result of the item in the commit cycle.
  always_comb begin
    count_d    = count_q;
    out_done_d = 1'b0;
    out_cls_d  = '0;
    out_pri_d  = '0;
    if (act_q == cprq_pkg::ACT_PUSH) begin
      if (push_ok) begin
        count_d    = count_q + CW'(1);
        out_done_d = 1'b1;
      end
    end else if (found) begin
      count_d    = count_q - CW'(1);
      out_done_d = 1'b1;
      out_cls_d  = cls_q;
      out_pri_d  = best_pri;
    end
    count_ext  = CMPW'(count_d);
    out_fill_d = count_ext[cprq_pkg::FILL_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cprq_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = cprq_pkg::ST_MATCH;
        end
      end
      cprq_pkg::ST_MATCH: begin
        state_d = cprq_pkg::ST_COMMIT;
      end
      cprq_pkg::ST_COMMIT: begin
        if (slot_free) begin
          state_d = cprq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cprq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cprq_pkg::ST_IDLE;
      limit_q     <= cprq_pkg::LIMIT_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      if (commit_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q <= s_axis_tuser;
      cls_q <= s_axis_tdata[3:0];
      pri_q <= s_axis_tdata[5:4];
    end
    if (commit_fire) begin
      out_done_q <= out_done_d;
      out_cls_q  <= out_cls_d;
      out_pri_q  <= out_pri_d;
      out_fill_q <= out_fill_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_done_q;
  assign m_axis_tdata  = {5'd0, out_fill_q, out_pri_q, out_cls_q};

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_single_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(load_new))
    else $error("more than one cell loaded by a push");

  a_count_in_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == cprq_pkg::ST_COMMIT))
    else $error("fill changed outside the commit cycle");

  a_result_after_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == cprq_pkg::ST_COMMIT))
    else $error("result raised without a commit");
`endif

endmodule
`default_nettype wire
